FILE: hw/rtl/bplc_pkg.sv
// Shared types, widths, constants and register defaults for the two-key
// light level controller. No dependencies; every other file imports it.
package bplc_pkg;

   // field widths
   localparam int READING_W   = 12;
   localparam int LEVEL_W     = 3;
   localparam int HOLD_W      = 7;
   localparam int WINDOW_W    = 7;
   localparam int FULL_CNT_W  = 8;
   localparam int LOWBAT_W    = 13;
   localparam int BLINK_W     = 6;
   localparam int IDLE_W      = 5;
   localparam int TICK_W      = 7;
   localparam int SECONDS_W   = 10;
   localparam int DUTY_W      = 8;
   localparam int STEP_W      = 5;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;

   // default parameter values
   localparam int MAX_LEVEL_DEFAULT        = 5;
   localparam int TICKS_PER_SECOND_DEFAULT = 100;

   // fixed behavior constants
   localparam int HOLD_CAP       = 100;
   localparam int CLICK_MIN_HOLD = 4;
   localparam int FULL_CONFIRM   = 250;
   localparam int BLINK_ON       = 30;
   localparam int BLINK_PERIOD   = 60;
   localparam int SECONDS_CAP    = 1023;
   localparam int IDLE_CAP       = 31;
   localparam int DUTY_CAP       = 255;

   // register reset values
   localparam logic [READING_W-1:0] LOW_THRESHOLD_RST  = 12'd558;
   localparam logic [READING_W-1:0] HIGH_THRESHOLD_RST = 12'd772;
   localparam logic [LOWBAT_W-1:0]  LOWBAT_OFF_RST     = 13'd6000;
   localparam logic [IDLE_W-1:0]    IDLE_SLEEP_RST     = 5'd20;
   localparam logic [SECONDS_W-1:0] WORK_TIMEOUT_RST   = 10'd900;
   localparam logic [WINDOW_W-1:0]  DOUBLE_CLICK_RST   = 7'd100;
   localparam logic [DUTY_W-1:0]    DUTY_BASE_RST      = 8'd70;
   localparam logic [STEP_W-1:0]    DUTY_STEP_RST      = 5'd6;

   typedef enum logic [1:0] {
      CLASS_LOW  = 2'd0,
      CLASS_MID  = 2'd1,
      CLASS_HIGH = 2'd2,
      CLASS_FULL = 2'd3
   } battery_class_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LOW_THRESHOLD  = 3'd0,
      CSR_HIGH_THRESHOLD = 3'd1,
      CSR_LOWBAT_OFF     = 3'd2,
      CSR_IDLE_SLEEP     = 3'd3,
      CSR_WORK_TIMEOUT   = 3'd4,
      CSR_DOUBLE_CLICK   = 3'd5,
      CSR_DUTY_BASE      = 3'd6,
      CSR_DUTY_STEP      = 3'd7
   } csr_index_type;

   // battery classing outcome
   typedef struct packed {
      battery_class_type         cls;
      logic [FULL_CNT_W-1:0]     full_count;
   } class_result_type;

   // key click evaluator outputs
   typedef struct packed {
      logic [HOLD_W-1:0] hold;
      logic              click;
   } key_status_type;

endpackage

FILE: hw/rtl/bplc_if.sv
// Valid/ready channel interfaces: tick input, result output, register writes.
// Depends on bplc_pkg for field widths.
interface bplc_req_if
   import bplc_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic                 key_up_pressed;
   logic                 key_down_pressed;
   logic                 charging;
   logic [READING_W-1:0] battery_reading;

   modport source (output valid, key_up_pressed, key_down_pressed, charging,
                   battery_reading, input ready);
   modport sink   (input valid, key_up_pressed, key_down_pressed, charging,
                   battery_reading, output ready);
endinterface

interface bplc_rsp_if
   import bplc_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               pwm_enable;
   logic [DUTY_W-1:0]  pwm_duty;
   logic               led_on;
   logic [LEVEL_W-1:0] work_level;
   logic [1:0]         battery_class;
   logic               sleep_request;

   modport source (output valid, pwm_enable, pwm_duty, led_on, work_level,
                   battery_class, sleep_request, input ready);
   modport sink   (input valid, pwm_enable, pwm_duty, led_on, work_level,
                   battery_class, sleep_request, output ready);
endinterface

interface bplc_csr_if
   import bplc_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

FILE: hw/rtl/bplc_key_click.sv
// Key hold counter and release-click detector for one key.
// Depends on bplc_pkg.
module bplc_key_click
   import bplc_pkg::*;
(
   input  logic              pressed,
   input  logic              freeze,
   input  logic [HOLD_W-1:0] hold_ff,
   output key_status_type    status
);

   always_comb begin
      status.hold  = hold_ff;
      status.click = 1'b0;
      if (!freeze) begin
         if (pressed) begin
            if (hold_ff < HOLD_W'(HOLD_CAP)) begin
               status.hold = hold_ff + HOLD_W'(1);
            end
         end else begin
            // click on release after a long enough hold
            status.click = (hold_ff >= HOLD_W'(CLICK_MIN_HOLD));
            status.hold  = '0;
         end
      end
   end

endmodule

FILE: hw/rtl/button_pwm_level_controller_core.sv
// Top level of the two-key light level controller.
// Depends on bplc_pkg, bplc_if (channel interfaces) and bplc_key_click.
//
// Usage:
//  - req_chan carries one item per 10 ms tick: both key levels, the charger
//    level and an averaged 12-bit battery reading.
//  - rsp_chan returns exactly one item per tick: PWM enable and duty, LED
//    drive, work level, battery class and the sleep request.
//  - csr_chan writes the eight setup registers (index 0..7); always ready.
//    Write only while no tick is in flight.
//  - Path: a tick is captured in an input register, then one pass of
//    combinational update logic writes the state and the result register,
//    which drives rsp_chan.
//  - Throughput: one tick per cycle while rsp_chan.ready is high; the input
//    register refills in the same cycle its item moves to the result register.
//  - Stall: while rsp_chan.ready is low the result holds, the input register
//    keeps its item and req_chan.ready drops once both are full.
//  - Reset (synchronous, active high): level off, LED off, all counters
//    zero, battery class low, registers back to their defaults, both
//    pipeline registers empty.
module button_pwm_level_controller_core
   import bplc_pkg::*;
#(
   parameter int MAX_LEVEL        = MAX_LEVEL_DEFAULT,
   parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEFAULT
)(
   input  logic      clock,
   input  logic      reset,
   bplc_req_if.sink  req_chan,
   bplc_rsp_if.source rsp_chan,
   bplc_csr_if.sink  csr_chan
);

   // ---------------- setup registers ----------------
   logic [READING_W-1:0] low_thr_ff, high_thr_ff;
   logic [LOWBAT_W-1:0]  lowbat_off_ff;
   logic [IDLE_W-1:0]    idle_sleep_ff;
   logic [SECONDS_W-1:0] work_timeout_ff;
   logic [WINDOW_W-1:0]  dclick_ff;
   logic [DUTY_W-1:0]    duty_base_ff;
   logic [STEP_W-1:0]    duty_step_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_thr_ff      <= LOW_THRESHOLD_RST;
         high_thr_ff     <= HIGH_THRESHOLD_RST;
         lowbat_off_ff   <= LOWBAT_OFF_RST;
         idle_sleep_ff   <= IDLE_SLEEP_RST;
         work_timeout_ff <= WORK_TIMEOUT_RST;
         dclick_ff       <= DOUBLE_CLICK_RST;
         duty_base_ff    <= DUTY_BASE_RST;
         duty_step_ff    <= DUTY_STEP_RST;
      end else if (csr_chan.valid) begin
         unique case (csr_index_type'(csr_chan.index))
            CSR_LOW_THRESHOLD:  low_thr_ff      <= csr_chan.wdata[READING_W-1:0];
            CSR_HIGH_THRESHOLD: high_thr_ff     <= csr_chan.wdata[READING_W-1:0];
            CSR_LOWBAT_OFF:     lowbat_off_ff   <= csr_chan.wdata[LOWBAT_W-1:0];
            CSR_IDLE_SLEEP:     idle_sleep_ff   <= csr_chan.wdata[IDLE_W-1:0];
            CSR_WORK_TIMEOUT:   work_timeout_ff <= csr_chan.wdata[SECONDS_W-1:0];
            CSR_DOUBLE_CLICK:   dclick_ff       <= csr_chan.wdata[WINDOW_W-1:0];
            CSR_DUTY_BASE:      duty_base_ff    <= csr_chan.wdata[DUTY_W-1:0];
            CSR_DUTY_STEP:      duty_step_ff    <= csr_chan.wdata[STEP_W-1:0];
         endcase
      end
   end

   // ---------------- input register ----------------
   logic                 item_valid_ff;
   logic                 up_ff, down_ff, chg_ff;
   logic [READING_W-1:0] reading_ff;
   logic                 rsp_valid_ff;
   logic                 advance;

   // item moves to the result register when that one is free or draining
   assign advance        = item_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !item_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         item_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         up_ff      <= req_chan.key_up_pressed;
         down_ff    <= req_chan.key_down_pressed;
         chg_ff     <= req_chan.charging;
         reading_ff <= req_chan.battery_reading;
      end
   end

   // ---------------- controller state ----------------
   logic [LEVEL_W-1:0]    level_ff, level_in;
   logic [HOLD_W-1:0]     up_hold_ff, down_hold_ff;
   logic [WINDOW_W-1:0]   window_ff, window_in;
   battery_class_type     class_ff, class_in;
   logic [FULL_CNT_W-1:0] full_cnt_ff, full_cnt_in;
   logic [LOWBAT_W-1:0]   lowbat_ff, lowbat_in;
   logic [BLINK_W-1:0]    blink_ff, blink_in;
   logic                  led_ff, led_in;
   logic [IDLE_W-1:0]     idle_ff, idle_in;
   logic [TICK_W-1:0]     tick_ff, tick_in;
   logic [SECONDS_W-1:0]  seconds_ff, seconds_in;

   logic                  sleep_in;
   logic [DUTY_W-1:0]     duty_in;

   // battery classing; the full count saturates at the confirm limit
   function automatic class_result_type classify(
      input logic [READING_W-1:0]  reading,
      input logic [FULL_CNT_W-1:0] count,
      input logic [READING_W-1:0]  lo,
      input logic [READING_W-1:0]  hi
   );
      class_result_type      r;
      logic [FULL_CNT_W:0]   inc;
      inc          = {1'b0, count} + (FULL_CNT_W+1)'(1);
      r.full_count = count;
      if (reading < lo) begin
         r.cls = CLASS_LOW;
      end else if (reading > hi) begin
         if (inc > (FULL_CNT_W+1)'(FULL_CONFIRM)) begin
            r.cls        = CLASS_FULL;
            r.full_count = FULL_CNT_W'(FULL_CONFIRM);
         end else begin
            r.cls        = CLASS_HIGH;
            r.full_count = inc[FULL_CNT_W-1:0];
         end
      end else begin
         r.cls        = CLASS_MID;
         r.full_count = '0;
      end
      return r;
   endfunction

   // key evaluators, frozen while the charger is connected
   key_status_type up_key, down_key;

   bplc_key_click u_up_key (
      .pressed (up_ff),
      .freeze  (chg_ff),
      .hold_ff (up_hold_ff),
      .status  (up_key)
   );

   bplc_key_click u_down_key (
      .pressed (down_ff),
      .freeze  (chg_ff),
      .hold_ff (down_hold_ff),
      .status  (down_key)
   );

   // one tick of the controller, in the fixed order: second counter,
   // low-battery auto-off, classing, charger, keys, LED, sleep, duty
   always_comb begin
      logic [TICK_W:0]     tick_inc;
      logic [LOWBAT_W:0]   lowbat_inc;
      logic [LEVEL_W:0]    level_up;
      logic [DUTY_W+1:0]   duty_sum;
      class_result_type    cr;
      logic                idle_cond;

      level_in    = level_ff;
      window_in   = window_ff;
      lowbat_in   = lowbat_ff;
      blink_in    = blink_ff;
      led_in      = led_ff;
      idle_in     = idle_ff;
      seconds_in  = seconds_ff;
      sleep_in    = 1'b0;
      duty_in     = '0;
      level_up    = '0;

      // second counter; on-time uses the level at tick start
      tick_inc = {1'b0, tick_ff} + (TICK_W+1)'(1);
      tick_in  = tick_inc[TICK_W-1:0];
      if (tick_inc >= (TICK_W+1)'(TICKS_PER_SECOND)) begin
         tick_in = '0;
         if (level_ff != '0) begin
            if (seconds_ff < SECONDS_W'(SECONDS_CAP)) begin
               seconds_in = seconds_ff + SECONDS_W'(1);
            end
         end else begin
            seconds_in = '0;
         end
      end

      // low-battery auto-off, judged on last tick's class
      lowbat_inc = {1'b0, lowbat_ff} + (LOWBAT_W+1)'(1);
      if (class_ff == CLASS_LOW && level_ff != '0) begin
         lowbat_in = lowbat_inc[LOWBAT_W-1:0];
         if (lowbat_inc >= {1'b0, lowbat_off_ff}) begin
            lowbat_in = '0;
            level_in  = '0;
         end
      end else begin
         lowbat_in = '0;
      end

      cr          = classify(reading_ff, full_cnt_ff, low_thr_ff, high_thr_ff);
      class_in    = cr.cls;
      full_cnt_in = cr.full_count;

      // charger: light off, LED steady when full, else blinking
      if (chg_ff) begin
         level_in = '0;
         if (class_in == CLASS_FULL) begin
            led_in = 1'b1;
         end else begin
            led_in   = (blink_ff < BLINK_W'(BLINK_ON));
            blink_in = blink_ff + BLINK_W'(1);
            if (blink_in > BLINK_W'(BLINK_PERIOD)) begin
               blink_in = '0;
            end
         end
      end

      // double-click window runs down even while charging
      if (window_ff != '0) begin
         window_in = window_ff - WINDOW_W'(1);
      end

      // key clicks (never fire while charging)
      if (up_key.click) begin
         if (level_in == '0) begin
            if (window_in != '0) begin
               level_in = LEVEL_W'(1);
            end
            window_in = dclick_ff;
         end else begin
            window_in = '0;
            level_up  = {1'b0, level_in} + (LEVEL_W+1)'(1);
            level_in  = level_up[LEVEL_W-1:0];
            if (level_up > (LEVEL_W+1)'(MAX_LEVEL)) begin
               level_in = '0;
            end
         end
      end
      if (down_key.click && level_in != '0) begin
         level_in = level_in - LEVEL_W'(1);
      end

      if (level_in != '0) begin
         led_in = 1'b1;
      end

      // sleep request from idle run or on-time timeout
      idle_cond = (level_in == '0) && (up_key.hold == '0) && (down_key.hold == '0)
                  && !chg_ff && (window_in == '0);
      if (idle_cond) begin
         if (idle_ff < IDLE_W'(IDLE_CAP)) begin
            idle_in = idle_ff + IDLE_W'(1);
         end
         if (idle_in > idle_sleep_ff) begin
            sleep_in = 1'b1;
         end
      end else begin
         idle_in = '0;
      end
      if (seconds_in > work_timeout_ff) begin
         sleep_in = 1'b1;
      end
      if (sleep_in) begin
         // battery is classed again with the same reading
         cr          = classify(reading_ff, full_cnt_in, low_thr_ff, high_thr_ff);
         class_in    = cr.cls;
         full_cnt_in = cr.full_count;
         led_in      = 1'b0;
         idle_in     = '0;
         level_in    = '0;
      end

      // duty = base + step * level, saturated
      duty_sum = {2'b00, duty_base_ff}
               + ({{(DUTY_W+2-STEP_W){1'b0}}, duty_step_ff}
                  * {{(DUTY_W+2-LEVEL_W){1'b0}}, level_in});
      if (level_in != '0) begin
         duty_in = (duty_sum > (DUTY_W+2)'(DUTY_CAP)) ? DUTY_W'(DUTY_CAP)
                                                      : duty_sum[DUTY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= '0;
         up_hold_ff   <= '0;
         down_hold_ff <= '0;
         window_ff    <= '0;
         class_ff     <= CLASS_LOW;
         full_cnt_ff  <= '0;
         lowbat_ff    <= '0;
         blink_ff     <= '0;
         led_ff       <= 1'b0;
         idle_ff      <= '0;
         tick_ff      <= '0;
         seconds_ff   <= '0;
      end else if (advance) begin
         level_ff     <= level_in;
         up_hold_ff   <= up_key.hold;
         down_hold_ff <= down_key.hold;
         window_ff    <= window_in;
         class_ff     <= class_in;
         full_cnt_ff  <= full_cnt_in;
         lowbat_ff    <= lowbat_in;
         blink_ff     <= blink_in;
         led_ff       <= led_in;
         idle_ff      <= idle_in;
         tick_ff      <= tick_in;
         seconds_ff   <= seconds_in;
      end
   end

   // ---------------- result register ----------------
   logic               pwm_en_ff;
   logic [DUTY_W-1:0]  duty_ff;
   logic               led_out_ff;
   logic [LEVEL_W-1:0] level_out_ff;
   logic [1:0]         class_out_ff;
   logic               sleep_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pwm_en_ff    <= (level_in != '0);
         duty_ff      <= duty_in;
         led_out_ff   <= led_in;
         level_out_ff <= level_in;
         class_out_ff <= class_in;
         sleep_ff     <= sleep_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.pwm_enable    = pwm_en_ff;
   assign rsp_chan.pwm_duty      = duty_ff;
   assign rsp_chan.led_on        = led_out_ff;
   assign rsp_chan.work_level    = level_out_ff;
   assign rsp_chan.battery_class = class_out_ff;
   assign rsp_chan.sleep_request = sleep_ff;

endmodule

FILE: tb/bplc_light_checker.sv
// Checker for the two-key light level controller: watches the tick, result and
// register channels, predicts each tick's result and compares field by field.
// Depends on bplc_pkg and the channel interfaces in bplc_if.
module bplc_light_checker
   import bplc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   bplc_req_if  req_mon,
   bplc_rsp_if  rsp_mon,
   bplc_csr_if  csr_mon,
   output int   mismatch_count,
   output int   pending_count,
   output int   checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRINT_CAP = 100;

   typedef struct packed {
      logic               pwm_enable;
      logic [DUTY_W-1:0]  pwm_duty;
      logic               led_on;
      logic [LEVEL_W-1:0] work_level;
      logic [1:0]         battery_class;
      logic               sleep_request;
   } light_out_type;

   light_out_type expected_lights[$];
   light_out_type got, want, next_light;

   // register copy
   logic [READING_W-1:0] low_thr, high_thr;
   logic [LOWBAT_W-1:0]  lowbat_limit;
   logic [IDLE_W-1:0]    idle_limit;
   logic [SECONDS_W-1:0] timeout_sec;
   logic [WINDOW_W-1:0]  window_len;
   logic [DUTY_W-1:0]    duty_base;
   logic [STEP_W-1:0]    duty_step;

   // light state copy
   int level, up_hold, down_hold, window, full_count, lowbat_count;
   int blink, idle, tick_count, on_seconds;
   battery_class_type grade;
   logic charging_now, led;

   task automatic report(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) $display("%0t ns: %s", $time, msg);
   endtask

   task automatic clear_light();
      low_thr      = LOW_THRESHOLD_RST;
      high_thr     = HIGH_THRESHOLD_RST;
      lowbat_limit = LOWBAT_OFF_RST;
      idle_limit   = IDLE_SLEEP_RST;
      timeout_sec  = WORK_TIMEOUT_RST;
      window_len   = DOUBLE_CLICK_RST;
      duty_base    = DUTY_BASE_RST;
      duty_step    = DUTY_STEP_RST;
      level = 0; up_hold = 0; down_hold = 0; window = 0; full_count = 0;
      lowbat_count = 0; blink = 0; idle = 0; tick_count = 0; on_seconds = 0;
      grade = CLASS_LOW;
      charging_now = 1'b0;
      led = 1'b0;
   endtask

   task automatic write_setting(input logic [CSR_INDEX_W-1:0] idx,
                                input logic [CSR_DATA_W-1:0] data);
      case (csr_index_type'(idx))
         CSR_LOW_THRESHOLD:  low_thr      = data[READING_W-1:0];
         CSR_HIGH_THRESHOLD: high_thr     = data[READING_W-1:0];
         CSR_LOWBAT_OFF:     lowbat_limit = data[LOWBAT_W-1:0];
         CSR_IDLE_SLEEP:     idle_limit   = data[IDLE_W-1:0];
         CSR_WORK_TIMEOUT:   timeout_sec  = data[SECONDS_W-1:0];
         CSR_DOUBLE_CLICK:   window_len   = data[WINDOW_W-1:0];
         CSR_DUTY_BASE:      duty_base    = data[DUTY_W-1:0];
         CSR_DUTY_STEP:      duty_step    = data[STEP_W-1:0];
         default: ;
      endcase
   endtask

   task automatic grade_battery(input logic [READING_W-1:0] reading);
      if (reading < low_thr) begin
         grade = CLASS_LOW;
      end else if (reading > high_thr) begin
         grade = CLASS_HIGH;
         full_count++;
         if (full_count > FULL_CONFIRM) begin
            full_count = FULL_CONFIRM;
            grade = CLASS_FULL;
         end
      end else begin
         grade = CLASS_MID;
         full_count = 0;
      end
   endtask

   // click fires on release after a long enough hold
   task automatic key_release(inout int hold, input logic pressed, output logic click);
      click = 1'b0;
      if (pressed) begin
         if (hold < HOLD_CAP) hold++;
      end else begin
         click = (hold >= CLICK_MIN_HOLD);
         hold = 0;
      end
   endtask

   task automatic advance_tick(input logic up, input logic dn, input logic chg,
                               input logic [READING_W-1:0] reading,
                               output light_out_type res);
      logic up_click, dn_click, sleep_now;
      int duty;
      sleep_now = 1'b0;
      duty = 0;
      up_click = 1'b0;
      dn_click = 1'b0;

      tick_count++;
      if (tick_count >= TICKS_PER_SECOND_DEFAULT) begin
         tick_count = 0;
         if (level > 0) begin
            if (on_seconds < SECONDS_CAP) on_seconds++;
         end else begin
            on_seconds = 0;
         end
      end

      // auto-off uses last tick's grade
      if (grade == CLASS_LOW && level > 0) begin
         lowbat_count++;
         if (lowbat_count >= lowbat_limit) begin
            lowbat_count = 0;
            level = 0;
         end
      end else begin
         lowbat_count = 0;
      end

      grade_battery(reading);

      if (chg) begin
         charging_now = 1'b1;
         level = 0;
         if (grade == CLASS_FULL) begin
            led = 1'b1;
         end else begin
            led = (blink < BLINK_ON);
            blink++;
            if (blink > BLINK_PERIOD) blink = 0;
         end
      end else begin
         charging_now = 1'b0;
      end

      if (window > 0) window--;
      if (!charging_now) begin
         key_release(up_hold, up, up_click);
         if (up_click) begin
            if (level == 0) begin
               if (window > 0) level = 1;
               window = int'(window_len);
            end else begin
               window = 0;
               level++;
               if (level > MAX_LEVEL_DEFAULT) level = 0;
            end
         end
         key_release(down_hold, dn, dn_click);
         if (dn_click && level > 0) level--;
      end

      if (level > 0) led = 1'b1;

      if (level == 0 && up_hold == 0 && down_hold == 0 && !charging_now && window == 0)
      begin
         if (idle < IDLE_CAP) idle++;
         if (idle > idle_limit) sleep_now = 1'b1;
      end else begin
         idle = 0;
      end
      if (on_seconds > timeout_sec) sleep_now = 1'b1;
      if (sleep_now) begin
         grade_battery(reading);
         led = 1'b0;
         idle = 0;
         level = 0;
      end

      if (level > 0) begin
         duty = duty_base + duty_step * level;
         if (duty > DUTY_CAP) duty = DUTY_CAP;
      end

      res.pwm_enable    = (level > 0);
      res.pwm_duty      = duty[DUTY_W-1:0];
      res.led_on        = led;
      res.work_level    = level[LEVEL_W-1:0];
      res.battery_class = grade;
      res.sleep_request = sleep_now;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_light();
         expected_lights.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.pwm_enable, rsp_mon.pwm_duty, rsp_mon.led_on,
                    rsp_mon.work_level, rsp_mon.battery_class, rsp_mon.sleep_request};
            if (expected_lights.size() == 0) begin
               report("result item with no tick outstanding");
            end else begin
               want = expected_lights.pop_front();
               if (got.pwm_enable !== want.pwm_enable)
                  report($sformatf("result %0d: pwm_enable got %0b want %0b",
                                   checked_count, got.pwm_enable, want.pwm_enable));
               if (got.pwm_duty !== want.pwm_duty)
                  report($sformatf("result %0d: pwm_duty got %0d want %0d",
                                   checked_count, got.pwm_duty, want.pwm_duty));
               if (got.led_on !== want.led_on)
                  report($sformatf("result %0d: led_on got %0b want %0b",
                                   checked_count, got.led_on, want.led_on));
               if (got.work_level !== want.work_level)
                  report($sformatf("result %0d: work_level got %0d want %0d",
                                   checked_count, got.work_level, want.work_level));
               if (got.battery_class !== want.battery_class)
                  report($sformatf("result %0d: battery_class got %0d want %0d",
                                   checked_count, got.battery_class, want.battery_class));
               if (got.sleep_request !== want.sleep_request)
                  report($sformatf("result %0d: sleep_request got %0b want %0b",
                                   checked_count, got.sleep_request, want.sleep_request));
            end
            checked_count++;
         end
         if (csr_mon.valid && csr_mon.ready) write_setting(csr_mon.index, csr_mon.wdata);
         if (req_mon.valid && req_mon.ready) begin
            advance_tick(req_mon.key_up_pressed, req_mon.key_down_pressed,
                         req_mon.charging, req_mon.battery_reading, next_light);
            expected_lights.push_back(next_light);
         end
      end
      pending_count = expected_lights.size();
   end

endmodule

FILE: tb/button_pwm_level_controller_core_tb.sv
// Testbench top for the two-key light level controller: drives ticks and
// register writes, paces the result side and gives the verdict.
// Depends on bplc_pkg, bplc_if, the core RTL and bplc_light_checker.
module button_pwm_level_controller_core_tb
   import bplc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_CYCLES = 2000;  // far above the long output stall
   localparam int LONG_STALL      = 300;   // receiver hold-off for back-pressure
   localparam int SETTLE_CYCLES   = 4;     // pause after the last result drains
   localparam int PHASE_TICKS     = 250;

   // how each side idles
   typedef enum int {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_type;
   // battery reading regimes, held over stretches so that full can be confirmed
   typedef enum int {SUPPLY_LOW, SUPPLY_MID, SUPPLY_HIGH, SUPPLY_EDGE, SUPPLY_ANY} supply_type;

   logic clock;
   logic reset;

   bplc_req_if req_chan();
   bplc_rsp_if rsp_chan();
   bplc_csr_if csr_chan();

   int mismatches, pending, checked;

   int send_gap_pct, recv_stall_pct;
   int stall_asked, stall_done, stall_left;
   int ticks_sent, quiet_cycles;
   supply_type supply_mode;
   int supply_left;

   // testbench copy of the settings that shape the stimulus
   logic [READING_W-1:0] cur_low, cur_high;
   int cur_window;

   button_pwm_level_controller_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   bplc_light_checker light_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_mon        (csr_chan),
      .mismatch_count (mismatches),
      .pending_count  (pending),
      .checked_count  (checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: random stalls per pace, plus a long hold-off when the
   // stimulus asks for one. The hold-off is counted here, not by the sender.
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else if (stall_asked != stall_done) begin
            stall_done++;
            stall_left = LONG_STALL - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog: any run of cycles with no handshake on any channel that
   // outlasts the limit means the block has hung.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             (csr_chan.valid && csr_chan.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_CYCLES) begin
               $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                        quiet_cycles, pending);
               $display("button_pwm_level_controller_core_tb: done, errors");
               $finish;
            end
         end
      end
   end

   task automatic set_pace(input pace_type p);
      case (p)
         PACE_FULL:        begin send_gap_pct = 0;  recv_stall_pct = 0;  end
         PACE_SEND_GAPS:   begin send_gap_pct = 60; recv_stall_pct = 0;  end
         PACE_RECV_STALLS: begin send_gap_pct = 0;  recv_stall_pct = 60; end
         default:          begin send_gap_pct = 9;  recv_stall_pct = 9;  end
      endcase
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_tick(input logic up, input logic dn, input logic chg,
                            input logic [READING_W-1:0] rd);
      while ($urandom_range(99) < send_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid            <= 1'b1;
      req_chan.key_up_pressed   <= up;
      req_chan.key_down_pressed <= dn;
      req_chan.charging         <= chg;
      req_chan.battery_reading  <= rd;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      ticks_sent++;
      @(negedge clock);
   endtask

   // Reading for the next tick; regimes last a while so that long high runs
   // reach the full confirmation and low runs reach the auto-off.
   function automatic logic [READING_W-1:0] next_reading();
      if (supply_left == 0) begin
         supply_mode = supply_type'($urandom_range(4));
         if (supply_mode == SUPPLY_HIGH && $urandom_range(9) < 4)
            supply_left = $urandom_range(300, 260);
         else
            supply_left = $urandom_range(80, 5);
      end
      supply_left--;
      case (supply_mode)
         SUPPLY_LOW: begin
            if (cur_low == 0) return READING_W'($urandom_range(4095));
            return READING_W'($urandom_range(cur_low - 1));
         end
         SUPPLY_MID:  return READING_W'($urandom_range(cur_high, cur_low));
         SUPPLY_HIGH: begin
            if (cur_high == 12'hfff) return READING_W'($urandom_range(4095));
            return READING_W'($urandom_range(4095, cur_high + 1));
         end
         SUPPLY_EDGE: begin
            case ($urandom_range(5))
               0:       return '0;
               1:       return '1;
               2:       return cur_low - READING_W'(1);
               3:       return cur_low;
               4:       return cur_high;
               default: return cur_high + READING_W'(1);
            endcase
         end
         default: return READING_W'($urandom_range(4095));
      endcase
   endfunction

   task automatic tick(input logic up, input logic dn, input logic chg);
      send_tick(up, dn, chg, next_reading());
   endtask

   // mostly valid clicks, some too short, a few long enough to saturate
   function automatic int pick_hold();
      int r;
      r = $urandom_range(99);
      if (r < 10) return $urandom_range(3, 1);
      if (r < 15) return $urandom_range(105, 95);
      return $urandom_range(8, 4);
   endfunction

   task automatic hold_keys(input logic up, input logic dn, input int n);
      repeat (n) tick(up, dn, 1'b0);
      tick(1'b0, 1'b0, 1'b0);
   endtask

   task automatic do_gesture();
      int pick, gap;
      pick = $urandom_range(99);
      if (pick < 30) begin
         hold_keys(1'b1, 1'b0, pick_hold());
      end else if (pick < 48) begin
         // double click, gap mostly inside the window
         if ($urandom_range(3) == 0) gap = $urandom_range(cur_window + 3);
         else gap = $urandom_range(cur_window / 2);
         hold_keys(1'b1, 1'b0, pick_hold());
         repeat (gap) tick(1'b0, 1'b0, 1'b0);
         hold_keys(1'b1, 1'b0, pick_hold());
      end else if (pick < 63) begin
         hold_keys(1'b0, 1'b1, pick_hold());
      end else if (pick < 70) begin
         hold_keys(1'b1, 1'b1, pick_hold());
      end else if (pick < 80) begin
         repeat ($urandom_range(40, 1)) tick(1'b0, 1'b0, 1'b0);
      end else if (pick < 88) begin
         // charger on, keys should be frozen
         repeat ($urandom_range(80, 1))
            tick(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1);
      end else begin
         repeat ($urandom_range(10, 1))
            tick(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom_range(4) == 0);
      end
   endtask

   // random part of a phase; pace rotates through all four modes
   task automatic run_gestures(input int count, input int rot);
      int start, quarter;
      start = ticks_sent;
      while (ticks_sent - start < count) begin
         quarter = (ticks_sent - start) * 4 / count;
         set_pace(pace_type'((quarter + rot) % 4));
         do_gesture();
      end
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.wdata <= val;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic apply_settings(input int lo, input int hi, input int lowbat,
                                 input int idle_ticks, input int timeout,
                                 input int dclick, input int base, input int step);
      write_csr(CSR_LOW_THRESHOLD, CSR_DATA_W'(lo));
      write_csr(CSR_HIGH_THRESHOLD, CSR_DATA_W'(hi));
      write_csr(CSR_LOWBAT_OFF, CSR_DATA_W'(lowbat));
      write_csr(CSR_IDLE_SLEEP, CSR_DATA_W'(idle_ticks));
      write_csr(CSR_WORK_TIMEOUT, CSR_DATA_W'(timeout));
      write_csr(CSR_DOUBLE_CLICK, CSR_DATA_W'(dclick));
      write_csr(CSR_DUTY_BASE, CSR_DATA_W'(base));
      write_csr(CSR_DUTY_STEP, CSR_DATA_W'(step));
      csr_chan.valid <= 1'b0;
      cur_low    = READING_W'(lo);
      cur_high   = READING_W'(hi);
      cur_window = dclick;
   endtask

   // stop offering, let every outstanding result drain, then a short pause
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // directed click: four held ticks then release
   task automatic directed_click(input logic up, input logic dn,
                                 input logic [READING_W-1:0] rd);
      repeat (CLICK_MIN_HOLD) send_tick(up, dn, 1'b0, rd);
      send_tick(1'b0, 1'b0, 1'b0, rd);
   endtask

   initial begin
      reset                     <= 1'b1;
      req_chan.valid            <= 1'b0;
      req_chan.key_up_pressed   <= 1'b0;
      req_chan.key_down_pressed <= 1'b0;
      req_chan.charging         <= 1'b0;
      req_chan.battery_reading  <= '0;
      csr_chan.valid            <= 1'b0;
      csr_chan.index            <= CSR_LOW_THRESHOLD;
      csr_chan.wdata            <= '0;
      set_pace(PACE_FULL);
      stall_asked  = 0;
      supply_left  = 0;
      supply_mode  = SUPPLY_ANY;
      cur_low      = LOW_THRESHOLD_RST;
      cur_high     = HIGH_THRESHOLD_RST;
      cur_window   = int'(DOUBLE_CLICK_RST);
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Directed, reset settings: reading extremes and threshold edges while
      // off, a double click to turn on, an up step, then charging with a key
      // down (key ignored, light forced off, LED blinking).
      send_tick(1'b0, 1'b0, 1'b0, 12'd0);
      send_tick(1'b0, 1'b0, 1'b0, 12'd557);
      send_tick(1'b0, 1'b0, 1'b0, 12'd558);
      send_tick(1'b0, 1'b0, 1'b0, 12'd772);
      send_tick(1'b0, 1'b0, 1'b0, 12'd773);
      send_tick(1'b0, 1'b0, 1'b0, 12'd4095);
      directed_click(1'b1, 1'b0, 12'd700);
      directed_click(1'b1, 1'b0, 12'd700);
      directed_click(1'b1, 1'b0, 12'd4095);
      send_tick(1'b0, 1'b1, 1'b1, 12'd300);
      send_tick(1'b0, 1'b0, 1'b1, 12'd2000);

      run_gestures(PHASE_TICKS, 0);

      // Low ends of the limits, widest double click window, duty saturating,
      // class always mid, sleep on any idle tick or after one second on. Starts
      // under a long output hold-off so the block fills and stalls its input.
      settle();
      apply_settings(0, 4095, 1, 0, 0, 127, 255, 31);
      stall_asked++;
      run_gestures(PHASE_TICKS, 1);

      // Inverted thresholds, no double click window, idle sleep never, top of
      // the auto-off range, a long timeout, zero duty terms.
      settle();
      apply_settings(4095, 0, 8191, 31, 1000, 0, 0, 0);
      run_gestures(PHASE_TICKS, 2);

      // short auto-off and timeout, narrow window, duty clipping at high levels
      settle();
      apply_settings(1000, 3000, 20, 5, 2, 10, 200, 15);
      run_gestures(PHASE_TICKS, 3);

      // random values across each register's full width
      settle();
      apply_settings($urandom_range(4095), $urandom_range(4095), $urandom_range(8191),
                     $urandom_range(31), $urandom_range(1023), $urandom_range(127),
                     $urandom_range(255), $urandom_range(31));
      run_gestures(PHASE_TICKS, 0);

      // back to reset values, opening with a high run long enough for full
      settle();
      apply_settings(int'(LOW_THRESHOLD_RST), int'(HIGH_THRESHOLD_RST),
                     int'(LOWBAT_OFF_RST), int'(IDLE_SLEEP_RST),
                     int'(WORK_TIMEOUT_RST), int'(DOUBLE_CLICK_RST),
                     int'(DUTY_BASE_RST), int'(DUTY_STEP_RST));
      supply_mode = SUPPLY_HIGH;
      supply_left = 280;
      run_gestures(PHASE_TICKS + 50, 1);

      settle();
      $display("run: %0d ticks under six register settings, %0d results compared",
               ticks_sent, checked);
      $display("run: clicks, holds, double click, charging, grading, sleep, long stall");
      if (mismatches == 0 && pending == 0)
         $display("button_pwm_level_controller_core_tb: done, clean");
      else
         $display("button_pwm_level_controller_core_tb: done, errors");
      $finish;
   end

endmodule
